FILE: design/blop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blop_pkg: shared types and constants
// Register indexes, widths, controller commands for the lattice option pricer.
// ----------------------------------------------------------------------------
package blop_pkg;
   localparam int DEF_MAX_STEPS = 1024;
   localparam int STEPS_W = 11;
   localparam int DATA_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_UP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISC = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS = 3'd4;
   localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

   // register reset values
   localparam logic [31:0] RST_UP = 32'h4000_0000;     // 1.0 in Q2.30
   localparam logic [31:0] RST_DOWN = 32'h4000_0000;   // 1.0 in Q2.30
   localparam logic [31:0] RST_PROB = 32'h4000_0000;   // 0.5 in Q1.31
   localparam logic [31:0] RST_DISC = ONE_Q31;
   localparam logic [STEPS_W-1:0] RST_STEPS = 11'd100;

   // datapath operation codes
   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_LOAD = 4'd1;      // capture item, clear flag
   localparam logic [3:0] OP_MUL_D = 4'd2;     // prod <= base*d
   localparam logic [3:0] OP_SAV_D = 4'd3;     // base <= round/sat(prod)
   localparam logic [3:0] OP_COPY = 4'd4;      // st <= base
   localparam logic [3:0] OP_MUL_U = 4'd5;     // prod <= st*u
   localparam logic [3:0] OP_SAV_U = 4'd6;     // st <= round/sat(prod)
   localparam logic [3:0] OP_LEAF = 4'd7;      // write payoff
   localparam logic [3:0] OP_MUL_P = 4'd8;     // prod <= V[i]*p
   localparam logic [3:0] OP_MUL_Q = 4'd9;     // prod <= V[i+1]*q, sum <= prod
   localparam logic [3:0] OP_ACC = 4'd10;      // sum <= sum + prod
   localparam logic [3:0] OP_RND = 4'd11;      // t <= round(sum)
   localparam logic [3:0] OP_MUL_DISC = 4'd12; // prod <= t*disc
   localparam logic [3:0] OP_WB = 4'd13;       // write round(prod)

   typedef struct packed {
      logic [3:0] op;
      logic       wr_en;
   } cmd_type;
endpackage

FILE: design/blop_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blop_ram: generic single-port-write, single-port-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module blop_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: design/blop_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blop_datapath: multiplier, payoff and induction arithmetic
// One 32x32 multiplier shared by terminal prices and backward induction.
// ----------------------------------------------------------------------------
module blop_datapath #(
   parameter int MAX_STEPS = blop_pkg::DEF_MAX_STEPS
) (
   input  logic                              clock,
   input  blop_pkg::cmd_type                 cmd,
   input  logic [$clog2(MAX_STEPS + 1)-1:0]  wr_addr,
   input  logic [$clog2(MAX_STEPS + 1)-1:0]  rd_addr,
   input  logic [31:0]                       spot,
   input  logic [31:0]                       strike,
   input  logic                              is_call,
   input  logic [31:0]                       up_factor,
   input  logic [31:0]                       down_factor,
   input  logic [31:0]                       prob_up,
   input  logic [31:0]                       step_discount,
   output logic [31:0]                       price,
   output logic                              saturated
);
   import blop_pkg::*;

   logic [31:0] base_ff, st_ff, strike_ff, t_ff;
   logic        call_ff, sat_ff;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] mul_a, mul_b;
   logic [31:0] p_c, q_c, disc_c;
   logic [63:0] rnd30;
   logic [33:0] q30;
   logic [31:0] q30_sat;
   logic        q30_ovf;
   logic [63:0] sum_ff;
   logic [63:0] rnd31;
   logic [63:0] drnd;
   logic [31:0] payoff;
   logic [31:0] rd_data;
   logic [31:0] wr_data;

   assign p_c = (prob_up > ONE_Q31) ? ONE_Q31 : prob_up;
   assign q_c = ONE_Q31 - p_c;
   assign disc_c = (step_discount > ONE_Q31) ? ONE_Q31 : step_discount;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = st_ff;
      mul_b = up_factor;
      case (cmd.op)
         OP_MUL_D: begin mul_a = base_ff; mul_b = down_factor; end
         OP_MUL_P: begin mul_a = rd_data; mul_b = p_c; end
         OP_MUL_Q: begin mul_a = rd_data; mul_b = q_c; end
         OP_MUL_DISC: begin mul_a = t_ff; mul_b = disc_c; end
         default: ;
      endcase
   end
   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // Q2.30 round and saturate
   assign rnd30 = prod_ff + 64'h2000_0000;
   assign q30 = rnd30[63:30];
   assign q30_ovf = |q30[33:32];
   assign q30_sat = q30_ovf ? 32'hFFFF_FFFF : q30[31:0];

   // Q1.31 rounding; both results fit in 32 bits
   assign rnd31 = sum_ff + 64'h4000_0000;
   assign drnd = prod_ff + 64'h4000_0000;

   always_comb begin
      if (call_ff) payoff = (st_ff > strike_ff) ? st_ff - strike_ff : '0;
      else         payoff = (strike_ff > st_ff) ? strike_ff - st_ff : '0;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (cmd.op)
         OP_LOAD: begin
            base_ff <= spot; strike_ff <= strike;
            call_ff <= is_call; sat_ff <= 1'b0;
         end
         OP_SAV_D: begin
            base_ff <= q30_sat; sat_ff <= sat_ff | q30_ovf;
         end
         OP_COPY: st_ff <= base_ff;
         OP_SAV_U: begin
            st_ff <= q30_sat; sat_ff <= sat_ff | q30_ovf;
         end
         OP_MUL_Q: sum_ff <= prod_ff;
         OP_ACC: sum_ff <= sum_ff + prod_ff;
         OP_RND: t_ff <= rnd31[62:31];
         default: ;
      endcase
   end

   assign wr_data = (cmd.op == OP_LEAF) ? payoff : drnd[62:31];

   blop_ram #(.WIDTH(32), .DEPTH(MAX_STEPS + 1)) u_nodes (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign price = rd_data;
   assign saturated = sat_ff;
endmodule

FILE: design/blop_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blop_ctrl: sequencer for terminal nodes and backward induction
// Walks node and level counters and issues datapath commands.
// ----------------------------------------------------------------------------
module blop_ctrl #(
   parameter int MAX_STEPS = blop_pkg::DEF_MAX_STEPS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [blop_pkg::STEPS_W-1:0]      steps,
   output blop_pkg::cmd_type                 cmd,
   output logic [$clog2(MAX_STEPS + 1)-1:0]  wr_addr,
   output logic [$clog2(MAX_STEPS + 1)-1:0]  rd_addr,
   output logic                              busy,
   output logic                              out_valid
);
   import blop_pkg::*;
   localparam int AW = $clog2(MAX_STEPS + 1);

   localparam logic [3:0] S_IDLE = 4'd0, S_COPY = 4'd1, S_MU0 = 4'd2, S_MU1 = 4'd3,
                          S_LEAF = 4'd4, S_MD0 = 4'd5, S_MD1 = 4'd6, S_R0 = 4'd7,
                          S_R1 = 4'd8, S_I0 = 4'd9, S_I1 = 4'd10, S_I2 = 4'd11,
                          S_I3 = 4'd12, S_WB = 4'd13, S_OUT = 4'd14;

   logic [3:0] state_ff, state_in;
   logic [AW-1:0] n_ff, n_in, i_ff, i_in, k_ff, k_in, j_ff, j_in;
   logic [AW-1:0] n_lim, i_inc;
   logic [31:0] steps_ext;
   logic out_ff, out_in;

   assign steps_ext = 32'(steps);
   assign n_lim = (steps_ext > 32'(MAX_STEPS)) ? AW'(MAX_STEPS) : AW'(steps_ext);
   assign i_inc = i_ff + AW'(1);

   always_comb begin
      state_in = state_ff; n_in = n_ff; i_in = i_ff; k_in = k_ff; j_in = j_ff;
      out_in = 1'b0;
      cmd = '0;
      wr_addr = i_ff;
      rd_addr = '0;
      unique case (state_ff)
         S_IDLE: if (start && !out_ff) begin
            // item captured at the accepting edge
            cmd.op = OP_LOAD; n_in = n_lim; i_in = '0; state_in = S_COPY;
         end
         S_COPY: begin
            cmd.op = OP_COPY; k_in = n_ff - i_ff;
            state_in = (n_ff == i_ff) ? S_LEAF : S_MU0;
         end
         S_MU0: begin cmd.op = OP_MUL_U; state_in = S_MU1; end
         S_MU1: begin
            cmd.op = OP_SAV_U; k_in = k_ff - AW'(1);
            state_in = (k_ff == AW'(1)) ? S_LEAF : S_MU0;
         end
         S_LEAF: begin
            cmd.op = OP_LEAF; cmd.wr_en = 1'b1;
            if (i_ff == n_ff) begin
               j_in = n_ff; i_in = '0;
               state_in = (n_ff == '0) ? S_OUT : S_R0;
            end else begin
               i_in = i_inc; state_in = S_MD0;
            end
         end
         S_MD0: begin cmd.op = OP_MUL_D; state_in = S_MD1; end
         S_MD1: begin cmd.op = OP_SAV_D; state_in = S_COPY; end
         S_R0: begin rd_addr = i_ff; state_in = S_R1; end
         S_R1: begin cmd.op = OP_MUL_P; rd_addr = i_inc; state_in = S_I0; end
         S_I0: begin cmd.op = OP_MUL_Q; state_in = S_I1; end
         S_I1: begin cmd.op = OP_ACC; state_in = S_I2; end
         S_I2: begin cmd.op = OP_RND; state_in = S_I3; end
         S_I3: begin cmd.op = OP_MUL_DISC; state_in = S_WB; end
         S_WB: begin
            cmd.op = OP_WB; cmd.wr_en = 1'b1;
            if (i_inc == j_ff) begin
               i_in = '0; j_in = j_ff - AW'(1);
               state_in = (j_ff == AW'(1)) ? S_OUT : S_R0;
            end else begin
               i_in = i_inc; state_in = S_R0;
            end
         end
         S_OUT: begin
            // read V[0]; it sits on rd_data during the strobe cycle
            rd_addr = '0; out_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_ff <= 1'b0;
         n_ff <= '0; i_ff <= '0; k_ff <= '0; j_ff <= '0;
      end else begin
         state_ff <= state_in; out_ff <= out_in;
         n_ff <= n_in; i_ff <= i_in; k_ff <= k_in; j_ff <= j_in;
      end
   end

   assign busy = (state_ff != S_IDLE) || out_ff;
   assign out_valid = out_ff;
endmodule

FILE: design/binomial_lattice_option_pricer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_lattice_option_pricer: CRR binomial European option pricer
// Terminal prices by repeated Q2.30 multiply, payoff, then backward induction.
// ----------------------------------------------------------------------------
// One item at a time: an item is taken at a rising edge with start high and
// busy low, and spot, strike and is_call are captured at that edge. For n
// lattice steps (n clamped to MAX_STEPS), terminal prices come from the one
// shared multiplier, each product a multiply then a round and saturate, plus
// a copy and a leaf write per node; backward induction covers n(n+1)/2 nodes,
// each reading both neighbors through the single RAM read port, with three
// products sharing the multiplier; then V[0] is read, then the strobe. busy
// holds through the strobe, so the next item is taken only after it. The
// result is valid on rsp_ for exactly one cycle with rsp_valid; the receiver
// cannot stall it. Write the configuration only while busy is low.
module binomial_lattice_option_pricer #(
   parameter int MAX_STEPS = blop_pkg::DEF_MAX_STEPS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_spot,
   input  logic [31:0] req_strike,
   input  logic        req_is_call,
   output logic        rsp_valid,
   output logic [31:0] rsp_price,
   output logic        rsp_saturated,
   input  logic        csr_wr_en,
   input  logic [blop_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata
);
   import blop_pkg::*;
   localparam int AW = $clog2(MAX_STEPS + 1);

   logic [31:0] up_ff, down_ff, prob_ff, disc_ff;
   logic [STEPS_W-1:0] steps_ff;
   cmd_type cmd;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0] price;
   logic sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff <= RST_UP; down_ff <= RST_DOWN;
         prob_ff <= RST_PROB; disc_ff <= RST_DISC;
         steps_ff <= RST_STEPS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_UP: up_ff <= csr_wdata;
            CSR_DOWN: down_ff <= csr_wdata;
            CSR_PROB: prob_ff <= csr_wdata;
            CSR_DISC: disc_ff <= csr_wdata;
            CSR_STEPS: steps_ff <= csr_wdata[STEPS_W-1:0];
            default: ;
         endcase
      end
   end

   blop_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .steps(steps_ff),
      .cmd(cmd), .wr_addr(wr_addr), .rd_addr(rd_addr),
      .busy(busy), .out_valid(rsp_valid)
   );

   blop_datapath #(.MAX_STEPS(MAX_STEPS)) u_dp (
      .clock(clock), .cmd(cmd), .wr_addr(wr_addr), .rd_addr(rd_addr),
      .spot(req_spot), .strike(req_strike),
      .is_call(req_is_call), .up_factor(up_ff), .down_factor(down_ff),
      .prob_up(prob_ff), .step_discount(disc_ff), .price(price), .saturated(sat)
   );

   assign rsp_price = price;
   assign rsp_saturated = sat;
endmodule
